### rtl/speed_interval_propagation_assert.svh
// Assertion macros for the speed interval propagation block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef SPEED_INTERVAL_PROPAGATION_ASSERT_SVH
`define SPEED_INTERVAL_PROPAGATION_ASSERT_SVH

// Implication checked at every clock edge outside reset
`define SIP_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must never hold outside reset
`define SIP_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

### rtl/sip_pkg.sv
// Shared types and constants for the speed interval propagation block.
// No dependencies.
`timescale 1ns / 1ps

package sip_pkg;

	localparam int CFG_W = 24;
	localparam int SQ_W  = 32;
	localparam int ENV_W = 25;

	// configuration register indexes
	localparam logic [2:0] REG_SPEED     = 3'd0;
	localparam logic [2:0] REG_YAW_RATE  = 3'd1;
	localparam logic [2:0] REG_LAT_ACC   = 3'd2;
	localparam logic [2:0] REG_TAN_ACC   = 3'd3;
	localparam logic [2:0] REG_YAW_ACC   = 3'd4;

	// reset values, Q8.16
	localparam logic [CFG_W-1:0] RST_SPEED    = 24'd131072;
	localparam logic [CFG_W-1:0] RST_YAW_RATE = 24'd196608;
	localparam logic [CFG_W-1:0] RST_LAT_ACC  = 24'd131072;
	localparam logic [CFG_W-1:0] RST_TAN_ACC  = 24'd98304;
	localparam logic [CFG_W-1:0] RST_YAW_ACC  = 24'd393216;

	typedef logic [2:0] status_t;
	localparam status_t ST_OK          = 3'd0;
	localparam status_t ST_BAD_RANGE   = 3'd1;
	localparam status_t ST_START_INF   = 3'd2;
	localparam status_t ST_EMPTY       = 3'd3;
	localparam status_t ST_END_UNREACH = 3'd4;
	localparam status_t ST_STOP_UNREACH = 3'd5;

	// input transaction fields that travel alongside the dividers
	typedef struct packed {
		logic [SQ_W-1:0]         smin;
		logic [SQ_W-1:0]         smax;
		logic [CFG_W-1:0]        len;
		logic signed [ENV_W-1:0] emin;
		logic signed [ENV_W-1:0] emax;
		logic                    stop;
		logic                    knz;
	} item_t;

endpackage

### rtl/sip_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Standalone; used by the speed interval propagation top level.
`timescale 1ns / 1ps

module sip_div #(
	parameter int QW = 40,
	parameter int DW = 24
) (
	input  logic          clk,
	input  logic [QW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	logic [DW-1:0] rem_s [0:QW];
	logic [QW-1:0] num_s [0:QW];
	logic [QW-1:0] quo_s [0:QW];
	logic [DW-1:0] den_s [0:QW];

	logic [DW-1:0] rem_n [1:QW];
	logic [QW-1:0] num_n [1:QW];
	logic [QW-1:0] quo_n [1:QW];

	assign rem_s[0] = '0;
	assign num_s[0] = num;
	assign quo_s[0] = '0;
	assign den_s[0] = den;

	// one trial subtract per stage
	always_comb begin
		logic [DW:0] trial;
		logic        ge;
		for (int j = 0; j < QW; j++) begin
			trial = {rem_s[j], num_s[j][QW-1]};
			ge = trial >= {1'b0, den_s[j]};
			rem_n[j+1] = ge ? DW'(trial - {1'b0, den_s[j]}) : trial[DW-1:0];
			quo_n[j+1] = {quo_s[j][QW-2:0], ge};
			num_n[j+1] = num_s[j] << 1;
		end
	end

	// stage registers
	for (genvar g = 1; g <= QW; g++) begin : g_stage
		always_ff @(posedge clk) begin
			rem_s[g] <= rem_n[g];
			quo_s[g] <= quo_n[g];
			num_s[g] <= num_n[g];
			den_s[g] <= den_s[g-1];
		end
	end

	assign quo = quo_s[QW];

endmodule

### rtl/speed_interval_propagation.sv
// Throughput: one transaction per cycle; busy is always low and results cannot stall.
// Three pipelined dividers of 24+FRAC_BITS stages each divide by |curvature|.
// Reset clears all valid bits and loads the configuration defaults.
// Holds the top level; depends on sip_pkg, sip_div and the assertion header.
`timescale 1ns / 1ps
`include "speed_interval_propagation_assert.svh"

module speed_interval_propagation import sip_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [2:0]              cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    start,
	output logic                    busy,
	input  logic [SQ_W-1:0]         start_sq_min,
	input  logic [SQ_W-1:0]         start_sq_max,
	input  logic [CFG_W-1:0]        edge_length,
	input  logic signed [CFG_W-1:0] edge_curvature,
	input  logic signed [ENV_W-1:0] env_speed_min,
	input  logic signed [ENV_W-1:0] env_speed_max,
	input  logic                    stop_at_end,
	output logic                    done,
	output status_t                 status,
	output logic [SQ_W-1:0]         reach_sq_min,
	output logic [SQ_W-1:0]         reach_sq_max,
	output logic [SQ_W-1:0]         dynamic_cap_sq,
	output logic [SQ_W-1:0]         endpoint_cap_sq
);

	localparam int QW       = CFG_W + FRAC_BITS;
	localparam int EPS_RAW0 = ((1 << FRAC_BITS) + 5000) / 10000;
	localparam int EPS_RAW  = (EPS_RAW0 == 0) ? 1 : EPS_RAW0;
	localparam logic [CFG_W-1:0] EPS = CFG_W'(EPS_RAW);
	localparam int STEP_W   = 2 * CFG_W + 1;

	function automatic logic [SQ_W-1:0] sat32(input logic [63:0] x);
		return (|x[63:32]) ? '1 : x[31:0];
	endfunction

	function automatic logic [SQ_W-1:0] shr_sat(input logic [63:0] p);
		logic [63:0] t;
		t = p >> FRAC_BITS;
		return sat32(t);
	endfunction

	// configuration registers
	logic [CFG_W-1:0] speed_limit_q, yaw_rate_limit_q, lat_acc_limit_q;
	logic [CFG_W-1:0] tan_acc_limit_q, yaw_acc_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_limit_q    <= RST_SPEED;
			yaw_rate_limit_q <= RST_YAW_RATE;
			lat_acc_limit_q  <= RST_LAT_ACC;
			tan_acc_limit_q  <= RST_TAN_ACC;
			yaw_acc_limit_q  <= RST_YAW_ACC;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SPEED:    speed_limit_q    <= cfg_data;
				REG_YAW_RATE: yaw_rate_limit_q <= cfg_data;
				REG_LAT_ACC:  lat_acc_limit_q  <= cfg_data;
				REG_TAN_ACC:  tan_acc_limit_q  <= cfg_data;
				REG_YAW_ACC:  yaw_acc_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: capture the transaction, take |curvature|
	logic             vld_s1;
	item_t            item_s1;
	logic [CFG_W-1:0] k_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		k_s1 <= edge_curvature[CFG_W-1] ? CFG_W'(-edge_curvature) : edge_curvature;
		item_s1.smin <= start_sq_min;
		item_s1.smax <= start_sq_max;
		item_s1.len  <= edge_length;
		item_s1.emin <= env_speed_min;
		item_s1.emax <= env_speed_max;
		item_s1.stop <= stop_at_end;
		item_s1.knz  <= |edge_curvature;
	end

	// dividers: yaw rate, lateral accel and yaw accel over |k|
	logic [QW-1:0] q_yaw, q_lat, q_acc;

	sip_div #(.QW(QW), .DW(CFG_W)) u_div_yaw (
		.clk(clk), .num({yaw_rate_limit_q, {FRAC_BITS{1'b0}}}), .den(k_s1), .quo(q_yaw));
	sip_div #(.QW(QW), .DW(CFG_W)) u_div_lat (
		.clk(clk), .num({lat_acc_limit_q, {FRAC_BITS{1'b0}}}), .den(k_s1), .quo(q_lat));
	sip_div #(.QW(QW), .DW(CFG_W)) u_div_acc (
		.clk(clk), .num({yaw_acc_limit_q, {FRAC_BITS{1'b0}}}), .den(k_s1), .quo(q_acc));

	// delay line matching the divider depth
	logic  vld_s2 [1:QW];
	item_t item_s2 [1:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 1; j <= QW; j++) vld_s2[j] <= 1'b0;
		end else begin
			vld_s2[1] <= vld_s1;
			for (int j = 2; j <= QW; j++) vld_s2[j] <= vld_s2[j-1];
		end
	end

	always_ff @(posedge clk) begin
		item_s2[1] <= item_s1;
		for (int j = 2; j <= QW; j++) item_s2[j] <= item_s2[j-1];
	end

	item_t it2;
	assign it2 = item_s2[QW];

	// stage 3: saturate quotients, accel cap, forward speed floor
	logic             vld_s3, yaw_sat_s3;
	item_t            item_s3;
	logic [SQ_W-1:0]  yaw_q_s3, lat_cap_s3;
	logic [CFG_W-1:0] acc_s3, ms_s3, emax_pos_s3;
	logic [63:0]      qy64, qa64;

	assign qy64 = 64'(q_yaw);
	assign qa64 = 64'(q_acc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else         vld_s3 <= vld_s2[QW];
	end

	always_ff @(posedge clk) begin
		item_s3     <= it2;
		yaw_sat_s3  <= |qy64[63:32];
		yaw_q_s3    <= qy64[31:0];
		lat_cap_s3  <= sat32(64'(q_lat));
		acc_s3      <= (it2.knz && qa64 < 64'(tan_acc_limit_q)) ? qa64[CFG_W-1:0]
			: tan_acc_limit_q;
		ms_s3       <= it2.stop ? '0
			: (it2.emin > $signed({1'b0, EPS}) ? it2.emin[CFG_W-1:0] : EPS);
		emax_pos_s3 <= (it2.emax > 0) ? it2.emax[CFG_W-1:0] : '0;
	end

	// stage 4: products
	logic                 vld_s4, yaw_sat_s4;
	item_t                item_s4;
	logic [SQ_W-1:0]      lat_cap_s4;
	logic [63:0]          yaw_p_s4;
	logic [2*CFG_W-1:0]   spd_p_s4, emax_p_s4, ms_p_s4, step_p_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else         vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		item_s4    <= item_s3;
		yaw_sat_s4 <= yaw_sat_s3;
		lat_cap_s4 <= lat_cap_s3;
		yaw_p_s4   <= 64'(yaw_q_s3) * 64'(yaw_q_s3);
		spd_p_s4   <= (2*CFG_W)'(speed_limit_q) * (2*CFG_W)'(speed_limit_q);
		emax_p_s4  <= (2*CFG_W)'(emax_pos_s3) * (2*CFG_W)'(emax_pos_s3);
		ms_p_s4    <= (2*CFG_W)'(ms_s3) * (2*CFG_W)'(ms_s3);
		step_p_s4  <= (2*CFG_W)'(acc_s3) * (2*CFG_W)'(item_s3.len);
	end

	// stage 5: scale products, dynamic cap
	logic              vld_s5;
	item_t             item_s5;
	logic [SQ_W-1:0]   dyn_s5, esq_s5, mssq_s5;
	logic [STEP_W-1:0] step_s5;
	logic [SQ_W-1:0]   yaw_cap, spd_sq, kcap;

	assign yaw_cap = yaw_sat_s4 ? '1 : shr_sat(yaw_p_s4);
	assign spd_sq  = shr_sat(64'(spd_p_s4));
	assign kcap    = (yaw_cap < lat_cap_s4) ? yaw_cap : lat_cap_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else         vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		item_s5 <= item_s4;
		dyn_s5  <= (item_s4.knz && kcap < spd_sq) ? kcap : spd_sq;
		esq_s5  <= shr_sat(64'(emax_p_s4));
		mssq_s5 <= shr_sat(64'(ms_p_s4));
		step_s5 <= STEP_W'(64'({step_p_s4, 1'b0}) >> FRAC_BITS);
	end

	// stage 6: endpoint cap, range and start checks
	logic              vld_s6, stop_s6;
	status_t           st_s6;
	logic [SQ_W-1:0]   dyn_s6, ecap_s6, amin_s6, amax_s6, mssq_s6;
	logic [STEP_W-1:0] step_s6;
	logic [SQ_W-1:0]   ecap5, amax5;
	logic              bad5;

	assign ecap5 = (esq_s5 < dyn_s5) ? esq_s5 : dyn_s5;
	assign amax5 = (item_s5.smax < dyn_s5) ? item_s5.smax : dyn_s5;
	assign bad5  = (item_s5.emin > item_s5.emax) || item_s5.emax[ENV_W-1]
		|| (ecap5 == '0 && !item_s5.stop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else         vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		stop_s6 <= item_s5.stop;
		dyn_s6  <= dyn_s5;
		ecap_s6 <= ecap5;
		amin_s6 <= item_s5.smin;
		amax_s6 <= amax5;
		mssq_s6 <= mssq_s5;
		step_s6 <= step_s5;
		priority if (bad5)                    st_s6 <= ST_BAD_RANGE;
		else if (item_s5.smin > amax5)        st_s6 <= ST_START_INF;
		else                                  st_s6 <= ST_OK;
	end

	// stage 7: move the interval by the step
	logic            vld_s7, stop_s7;
	status_t         st_s7;
	logic [SQ_W-1:0] dyn_s7, ecap_s7, rmin_s7, rmax_s7, mssq_s7;
	logic [SQ_W-1:0] rmin6, rmax6;
	logic [63:0]     sum6;

	assign rmin6 = (64'(amin_s6) > 64'(step_s6)) ? SQ_W'(64'(amin_s6) - 64'(step_s6)) : '0;
	assign sum6  = 64'(amax_s6) + 64'(step_s6);
	assign rmax6 = (sum6 < 64'(dyn_s6)) ? sum6[SQ_W-1:0] : dyn_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else         vld_s7 <= vld_s6;
	end

	always_ff @(posedge clk) begin
		stop_s7 <= stop_s6;
		dyn_s7  <= dyn_s6;
		ecap_s7 <= ecap_s6;
		mssq_s7 <= mssq_s6;
		rmin_s7 <= rmin6;
		rmax_s7 <= rmax6;
		st_s7   <= (st_s6 == ST_OK && rmin6 > rmax6) ? ST_EMPTY : st_s6;
	end

	// stage 8: intersect with the endpoint range, output registers
	logic            vld_s8;
	status_t         st_s8;
	logic [SQ_W-1:0] dyn_s8, ecap_s8, omin_s8, omax_s8;
	logic [SQ_W-1:0] lo7, hi7;

	assign lo7 = (rmin_s7 > mssq_s7) ? rmin_s7 : mssq_s7;
	assign hi7 = (rmax_s7 < ecap_s7) ? rmax_s7 : ecap_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s8 <= 1'b0;
		else         vld_s8 <= vld_s7;
	end

	always_ff @(posedge clk) begin
		dyn_s8  <= dyn_s7;
		ecap_s8 <= ecap_s7;
		priority if (st_s7 != ST_OK) begin
			st_s8   <= st_s7;
			omin_s8 <= '0;
			omax_s8 <= '0;
		end else if (lo7 > hi7) begin
			st_s8   <= ST_END_UNREACH;
			omin_s8 <= '0;
			omax_s8 <= '0;
		end else if (stop_s7) begin
			st_s8   <= (lo7 != '0) ? ST_STOP_UNREACH : ST_OK;
			omin_s8 <= '0;
			omax_s8 <= '0;
		end else begin
			st_s8   <= ST_OK;
			omin_s8 <= lo7;
			omax_s8 <= hi7;
		end
	end

	assign done            = vld_s8;
	assign status          = st_s8;
	assign reach_sq_min    = omin_s8;
	assign reach_sq_max    = omax_s8;
	assign dynamic_cap_sq  = dyn_s8;
	assign endpoint_cap_sq = ecap_s8;

	// checks
	`SIP_ASSERT_IMPL(a_fail_zero, done && status != ST_OK,
		reach_sq_min == '0 && reach_sq_max == '0, "failed transaction with nonzero reach")
	`SIP_ASSERT_IMPL(a_ok_order, done && status == ST_OK,
		reach_sq_min <= reach_sq_max && reach_sq_max <= endpoint_cap_sq, "reach out of order")
	`SIP_ASSERT_IMPL(a_cap_order, done,
		endpoint_cap_sq <= dynamic_cap_sq, "endpoint cap above dynamic cap")
	`SIP_ASSERT_NEVER(a_busy_low, busy, "busy raised")

endmodule

### tb/testbench.sv
// Self-checking testbench for speed_interval_propagation: squared-speed reach over one edge.
// Drives directed and random edges with random start gaps, predicts each result in fixed point.
// Depends on sip_pkg and the block RTL.
`timescale 1ns / 1ps

module testbench import sip_pkg::*; ();

	localparam int FB = 16;
	localparam int LATENCY = FB + 30;
	localparam longint M32 = 64'hFFFF_FFFF;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		logic [31:0] smin;
		logic [31:0] smax;
		logic [23:0] len;
		logic [23:0] curv;
		logic [24:0] emin;
		logic [24:0] emax;
		logic        stop;
	} edge_t;

	typedef struct {
		status_t     st;
		logic [31:0] rmin;
		logic [31:0] rmax;
		logic [31:0] dcap;
		logic [31:0] ecap;
	} reach_t;

	logic clk = 0, arst_n = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;
	logic start = 0, busy;
	logic [31:0] start_sq_min = '0, start_sq_max = '0;
	logic [23:0] edge_length = '0;
	logic signed [23:0] edge_curvature = '0;
	logic signed [24:0] env_speed_min = '0, env_speed_max = '0;
	logic stop_at_end = 0;
	logic done;
	status_t status;
	logic [31:0] reach_sq_min, reach_sq_max, dynamic_cap_sq, endpoint_cap_sq;

	speed_interval_propagation dut (.*);

	// limits as held by the block
	longint unsigned lim_speed, lim_yaw, lim_lat, lim_tan, lim_yacc;

	edge_t  pending_edges[$];
	reach_t expected_reach[$];
	int     mismatches = 0, accepted = 0, checked = 0;
	longint cycles = 0;
	bit     quiet_sender = 0;
	bit     stim_done = 0;
	int     gap = 0;

	initial forever #6 clk = ~clk;

	function automatic longint unsigned sat32(longint unsigned x);
		return x > M32 ? M32 : x;
	endfunction

	function automatic longint unsigned min_u(longint unsigned a, longint unsigned b);
		return a < b ? a : b;
	endfunction

	function automatic longint unsigned square_q(longint unsigned x);
		return sat32((x * x) >> FB);
	endfunction

	function automatic reach_t propagate(edge_t e);
		reach_t r;
		longint signed c, emn, emx;
		longint unsigned k, dyn, acc, ecap, q, ycap, lcap, amin, amax;
		longint unsigned step, rmin, rmax, lo, hi, ms, eps;
		c = longint'(signed'(e.curv));
		emn = longint'(signed'(e.emin));
		emx = longint'(signed'(e.emax));
		k = c < 0 ? -c : c;
		r = '{ST_OK, 0, 0, 0, 0};
		dyn = square_q(lim_speed);
		acc = lim_tan;
		if (k != 0) begin
			q = (lim_yaw << FB) / k;
			ycap = q > M32 ? M32 : sat32((q * q) >> FB);
			lcap = sat32((lim_lat << FB) / k);
			dyn = min_u(dyn, min_u(ycap, lcap));
			acc = min_u(acc, (lim_yacc << FB) / k);
		end
		ecap = min_u(dyn, square_q(emx > 0 ? emx : 0));
		r.dcap = dyn;
		r.ecap = ecap;
		if (emn > emx || emx < 0 || (ecap == 0 && !e.stop)) begin
			r.st = ST_BAD_RANGE;
			return r;
		end
		amin = e.smin;
		amax = min_u(e.smax, dyn);
		if (amin > amax) begin
			r.st = ST_START_INF;
			return r;
		end
		step = (2 * acc * e.len) >> FB;
		rmin = amin > step ? amin - step : 0;
		rmax = min_u(amax + step, dyn);
		if (rmin > rmax) begin
			r.st = ST_EMPTY;
			return r;
		end
		// forward speed floor, about 1e-4 m/s
		eps = ((64'd1 << FB) + 5000) / 10000;
		if (eps == 0) eps = 1;
		if (e.stop) ms = 0;
		else ms = (emn > 0 && emn > eps) ? emn : eps;
		lo = rmin > square_q(ms) ? rmin : square_q(ms);
		hi = min_u(rmax, ecap);
		if (lo > hi) begin
			r.st = ST_END_UNREACH;
			return r;
		end
		if (e.stop) begin
			if (lo != 0) r.st = ST_STOP_UNREACH;
			return r;
		end
		r.rmin = lo;
		r.rmax = hi;
		return r;
	endfunction

	// driver: one transaction per accepted start, random gaps
	always @(negedge clk) begin
		edge_t e;
		if (arst_n && !(start && busy)) begin
			if (start) accepted <= accepted + 1;
			if (gap > 0 || quiet_sender || pending_edges.size() == 0) begin
				start <= 0;
				if (gap > 0) gap <= gap - 1;
			end else begin
				e = pending_edges.pop_front();
				expected_reach = {expected_reach, propagate(e)};
				start <= 1;
				start_sq_min <= e.smin;
				start_sq_max <= e.smax;
				edge_length <= e.len;
				edge_curvature <= e.curv;
				env_speed_min <= e.emin;
				env_speed_max <= e.emax;
				stop_at_end <= e.stop;
				if (!stim_done && $urandom_range(0, 7) == 0) gap <= $urandom_range(1, 14);
			end
		end
	end

	// monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		reach_t x;
		cycles <= cycles + 1;
		if (arst_n && done) begin
			if (expected_reach.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected result, status %0d", status);
			end else begin
				x = expected_reach.pop_front();
				checked <= checked + 1;
				if (status !== x.st || reach_sq_min !== x.rmin || reach_sq_max !== x.rmax
					|| dynamic_cap_sq !== x.dcap || endpoint_cap_sq !== x.ecap) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display({"mismatch: exp st=%0d min=%h max=%h dcap=%h ecap=%h",
							" / got st=%0d min=%h max=%h dcap=%h ecap=%h"},
							x.st, x.rmin, x.rmax, x.dcap, x.ecap, status, reach_sq_min,
							reach_sq_max, dynamic_cap_sq, endpoint_cap_sq);
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("speed_interval_propagation regression: fail");
			$finish;
		end
	end

	task automatic write_limit(input logic [2:0] idx, input logic [23:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		case (idx)
			REG_SPEED:    lim_speed = val;
			REG_YAW_RATE: lim_yaw = val;
			REG_LAT_ACC:  lim_lat = val;
			REG_TAN_ACC:  lim_tan = val;
			default:      lim_yacc = val;
		endcase
	endtask

	task automatic drain();
		wait (pending_edges.size() == 0 && !start && expected_reach.size() == 0);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	// mostly realistic edges; some fully random noise
	function automatic edge_t random_edge();
		edge_t e;
		logic [31:0] a, b;
		if ($urandom_range(0, 4) == 0) begin
			e.smin = $urandom; e.smax = $urandom; e.len = 24'($urandom);
			e.curv = 24'($urandom); e.emin = 25'($urandom); e.emax = 25'($urandom);
			e.stop = 1'($urandom);
			return e;
		end
		a = $urandom_range(0, 5 << FB);
		b = a + $urandom_range(0, 2 << FB);
		e.smin = $urandom_range(0, 7) == 0 ? b : a;
		e.smax = $urandom_range(0, 7) == 0 ? a : b;
		e.len = 24'($urandom_range(0, 4 << FB));
		case ($urandom_range(0, 3))
			0: e.curv = 0;
			1: e.curv = 24'($urandom_range(0, 1 << 15));
			2: e.curv = 24'(-$urandom_range(1, 3 << FB));
			default: e.curv = 24'($urandom);
		endcase
		e.emin = $urandom_range(0, 5) == 0 ? 25'(-$urandom_range(0, 1 << FB))
			: 25'($urandom_range(0, 2 << FB));
		e.emax = 25'(e.emin + $urandom_range(0, 3 << FB)
			- ($urandom_range(0, 9) == 0 ? 25'h10000 : 25'h0));
		e.stop = $urandom_range(0, 4) == 0;
		return e;
	endfunction

	task automatic push_edge(input logic [31:0] smin, smax, input logic [23:0] len, curv,
		input logic [24:0] emin, emax, input logic stop);
		edge_t e;
		e = '{smin, smax, len, curv, emin, emax, stop};
		pending_edges = {pending_edges, e};
	endtask

	initial begin
		lim_speed = RST_SPEED; lim_yaw = RST_YAW_RATE; lim_lat = RST_LAT_ACC;
		lim_tan = RST_TAN_ACC; lim_yacc = RST_YAW_ACC;
		repeat (9) @(negedge clk);
		arst_n = 1;

		// directed: defaults, each status and the field extremes
		push_edge(0, 32'h20000, 24'h10000, 0, 25'h8000, 25'h18000, 0);
		push_edge(0, 32'h20000, 24'h10000, 0, 25'h18000, 25'h8000, 0);
		push_edge(0, 32'h20000, 24'h10000, 0, 0, 25'h1FFFFFF, 0);
		push_edge(0, 32'h20000, 24'h10000, 0, 0, 0, 0);
		push_edge(0, 0, 0, 0, 0, 0, 1);
		push_edge(32'h40000, 32'h50000, 24'h10000, 0, 0, 25'h20000, 0);
		push_edge(32'h30000, 32'h40000, 24'h100, 0, 0, 25'h4000, 0);
		push_edge(32'h30000, 32'h40000, 24'h100, 0, 0, 25'h20000, 1);
		push_edge(32'h10000, 32'h30000, 24'h40000, 0, 0, 25'h20000, 1);
		push_edge(0, 32'h10, 24'h1, 24'h1, 0, 25'h10000, 0);
		push_edge(0, 32'hFFFFFFFF, 24'hFFFFFF, 24'h800000, 25'h1000000, 25'hFFFFFF, 0);
		push_edge(32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 24'h7FFFFF, 25'hFFFFFF, 25'hFFFFFF, 1);
		push_edge(0, 32'h40000, 24'h8000, 24'hFF0000, 25'h1, 25'h30000, 0);
		push_edge(0, 32'h40000, 24'h8000, 24'h008000, 25'h1, 25'h30000, 0);
		push_edge(0, 32'h40000, 24'h0, 24'hFFFFFF, 25'h0, 25'h1, 0);
		for (int i = 0; i < 250; i++) pending_edges = {pending_edges, random_edge()};
		drain();

		// extreme limits: all zero, then all full scale
		for (int r = 0; r < 5; r++) write_limit(3'(r), 24'h0);
		for (int i = 0; i < 40; i++) pending_edges = {pending_edges, random_edge()};
		drain();
		for (int r = 0; r < 5; r++) write_limit(3'(r), 24'hFFFFFF);
		for (int i = 0; i < 80; i++) pending_edges = {pending_edges, random_edge()};
		// halfway through, hold the sender until everything is back
		wait (pending_edges.size() <= 40);
		quiet_sender = 1;
		wait (expected_reach.size() == 0);
		quiet_sender = 0;
		drain();

		// random limits
		for (int p = 0; p < 4; p++) begin
			for (int r = 0; r < 5; r++) write_limit(3'(r), 24'($urandom_range(0, 8 << FB)));
			for (int i = 0; i < 70; i++) pending_edges = {pending_edges, random_edge()};
			drain();
		end
		stim_done = 1;
		for (int i = 0; i < 50; i++) pending_edges = {pending_edges, random_edge()};
		drain();

		$display("covered %0d edges over seven limit settings, %0d results checked",
			accepted, checked);
		if (mismatches == 0 && expected_reach.size() == 0)
			$display("speed_interval_propagation regression: pass");
		else
			$display("speed_interval_propagation regression: fail");
		$finish;
	end

endmodule
